[rtl/dog2d_pkg.sv]
// ----------------------------------------------------------------------------
// dog2d_pkg
// Types, constants and tables shared by the difference-of-Gaussians pipeline.
// ----------------------------------------------------------------------------
package dog2d_pkg;

   localparam int D2_W      = 33;   // squared distance, unsigned Q16.16
   localparam int R2_W      = 32;   // squared radius, unsigned Q16.16
   localparam int LIM_W     = 37;   // 17 * r^2
   localparam int QUO_W     = 21;   // quotient t, Q5.16
   localparam int WGT_W     = 31;   // Q0.30 weight, up to 1.0
   localparam int TERM_W    = 18;   // signed Q.12 term
   localparam int HORNER_N  = 9;    // Taylor degree
   localparam int DIV_LAT   = QUO_W;
   localparam int TERM_LAT  = DIV_LAT + 3 * HORNER_N + 2;

   localparam logic [WGT_W-1:0] ONE_Q30 = WGT_W'(1) << 30;

   localparam logic [2:0] CSR_CENTER_AMP   = 3'd0;
   localparam logic [2:0] CSR_CENTER_RAD   = 3'd1;
   localparam logic [2:0] CSR_SURROUND_AMP = 3'd2;
   localparam logic [2:0] CSR_SURROUND_RAD = 3'd3;
   localparam logic [2:0] CSR_OFFSET_X     = 3'd4;
   localparam logic [2:0] CSR_OFFSET_Y     = 3'd5;

   // per-item side information carried down the term pipeline
   typedef struct packed {
      logic [4:0]  int_part;
      logic [15:0] frac;
      logic        force_zero;
      logic        force_one;
   } term_meta_type;

   // round(exp(-n) * 2^30)
   function automatic logic [WGT_W-1:0] exp_neg_int(input logic [4:0] n);
      logic [WGT_W-1:0] e;
      case (n)
         5'd0:  e = 31'd1073741824;
         5'd1:  e = 31'd395007542;
         5'd2:  e = 31'd145315154;
         5'd3:  e = 31'd53458457;
         5'd4:  e = 31'd19666268;
         5'd5:  e = 31'd7234816;
         5'd6:  e = 31'd2661540;
         5'd7:  e = 31'd979126;
         5'd8:  e = 31'd360200;
         5'd9:  e = 31'd132510;
         5'd10: e = 31'd48748;
         5'd11: e = 31'd17933;
         5'd12: e = 31'd6597;
         5'd13: e = 31'd2427;
         5'd14: e = 31'd893;
         5'd15: e = 31'd328;
         5'd16: e = 31'd121;
         default: e = '0;
      endcase
      return e;
   endfunction

endpackage

[rtl/dog2d_term.sv]
// ----------------------------------------------------------------------------
// dog2d_term
// One Gaussian term: amp * exp(-d2 / r2), pipelined restoring divide, Horner
// exponent series and amplitude scaling, one item per cycle when advancing.
// ----------------------------------------------------------------------------
module dog2d_term (
   input  logic                                  clock,
   input  logic                                  advance,
   input  logic [dog2d_pkg::D2_W-1:0]            d2,
   input  logic [dog2d_pkg::R2_W-1:0]            r2,
   input  logic [dog2d_pkg::LIM_W-1:0]           lim,
   input  logic signed [15:0]                    amp,
   output logic signed [dog2d_pkg::TERM_W-1:0]   term
);
   import dog2d_pkg::*;

   // divider stage registers
   logic [R2_W-1:0]     dr_ff [DIV_LAT];
   logic [QUO_W-1:0]    dq_ff [DIV_LAT];
   logic [QUO_W-1:0]    dl_ff [DIV_LAT];
   logic                dz_ff [DIV_LAT];
   logic                do_ff [DIV_LAT];

   // Horner stage registers
   logic [WGT_W-1:0]    ha_ff [HORNER_N];
   logic [WGT_W-1:0]    hbx_ff [HORNER_N];
   logic [WGT_W-1:0]    hbq_ff [HORNER_N];
   logic [WGT_W-1:0]    hp_ff [HORNER_N];
   term_meta_type       ma_ff [HORNER_N];
   term_meta_type       mb_ff [HORNER_N];
   term_meta_type       mc_ff [HORNER_N];

   logic [WGT_W-1:0]    w_ff;
   logic [WGT_W-1:0]    w_in;
   logic [TERM_W-1:0]   term_ff;
   logic [TERM_W-1:0]   term_in;

   // entry: far tail or zero radius settle the weight outright
   logic                ent_zero;
   logic                ent_one;
   always_comb begin
      if (r2 == '0) begin
         ent_zero = (d2 != '0);
         ent_one  = (d2 == '0);
      end else begin
         ent_zero = (LIM_W'(d2) >= lim);
         ent_one  = 1'b0;
      end
   end

   for (genvar i = 0; i < DIV_LAT; i++) begin : g_div
      logic [R2_W-1:0]  rem_cur;
      logic [QUO_W-1:0] low_cur;
      logic [QUO_W-1:0] quo_cur;
      logic             z_cur;
      logic             o_cur;
      logic [R2_W+1:0]  trial;
      logic             ge;
      logic [R2_W-1:0]  dr_in;
      logic [QUO_W-1:0] dq_in;
      logic [QUO_W-1:0] dl_in;
      if (i == 0) begin : g_first
         assign rem_cur = R2_W'(d2[D2_W-1:5]);
         assign low_cur = {d2[4:0], 16'h0000};
         assign quo_cur = '0;
         assign z_cur   = ent_zero;
         assign o_cur   = ent_one;
      end else begin : g_next
         assign rem_cur = dr_ff[i-1];
         assign low_cur = dl_ff[i-1];
         assign quo_cur = dq_ff[i-1];
         assign z_cur   = dz_ff[i-1];
         assign o_cur   = do_ff[i-1];
      end
      always_comb begin
         trial = {1'b0, rem_cur, low_cur[QUO_W-1]} - {2'b00, r2};
         ge    = !trial[R2_W+1];
         dr_in = ge ? trial[R2_W-1:0] : {rem_cur[R2_W-2:0], low_cur[QUO_W-1]};
         dq_in = {quo_cur[QUO_W-2:0], ge};
         dl_in = {low_cur[QUO_W-2:0], 1'b0};
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            dr_ff[i] <= dr_in;
            dq_ff[i] <= dq_in;
            dl_ff[i] <= dl_in;
            dz_ff[i] <= z_cur;
            do_ff[i] <= o_cur;
         end
      end
   end

   term_meta_type div_meta;
   always_comb begin
      div_meta.int_part   = dq_ff[DIV_LAT-1][QUO_W-1:16];
      div_meta.frac       = dq_ff[DIV_LAT-1][15:0];
      div_meta.force_zero = dz_ff[DIV_LAT-1];
      div_meta.force_one  = do_ff[DIV_LAT-1];
   end

   // p = 1 - f * p / k, for k from the top degree down to 1
   for (genvar j = 0; j < HORNER_N; j++) begin : g_horner
      localparam logic [3:0]  K     = 4'(HORNER_N - j);
      localparam logic [32:0] RECIP = 33'((64'd1 << 32) / (HORNER_N - j));
      logic [WGT_W-1:0]  p_cur;
      term_meta_type     m_cur;
      logic [46:0]       fp;
      logic [63:0]       mq;
      logic [34:0]       back;
      logic [WGT_W-1:0]  resid;
      logic [WGT_W-1:0]  quo;
      logic [WGT_W-1:0]  ha_in;
      logic [WGT_W-1:0]  hbq_in;
      logic [WGT_W-1:0]  hp_in;
      if (j == 0) begin : g_first
         assign p_cur = ONE_Q30;
         assign m_cur = div_meta;
      end else begin : g_next
         assign p_cur = hp_ff[j-1];
         assign m_cur = mc_ff[j-1];
      end
      always_comb begin
         fp     = 47'(m_cur.frac) * 47'(p_cur);
         ha_in  = fp[46:16];
         mq     = 64'(ha_ff[j]) * 64'(RECIP);
         hbq_in = mq[62:32];
         // reciprocal estimate is at most one low
         back   = 35'(hbq_ff[j]) * 35'(K);
         resid  = hbx_ff[j] - back[WGT_W-1:0];
         quo    = hbq_ff[j] + WGT_W'(resid >= WGT_W'(K));
         hp_in  = ONE_Q30 - quo;
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            ha_ff[j]  <= ha_in;
            ma_ff[j]  <= m_cur;
            hbx_ff[j] <= ha_ff[j];
            hbq_ff[j] <= hbq_in;
            mb_ff[j]  <= ma_ff[j];
            hp_ff[j]  <= hp_in;
            mc_ff[j]  <= mb_ff[j];
         end
      end
   end

   term_meta_type    fin_meta;
   logic [61:0]      ep;
   logic [15:0]      mag;
   logic [46:0]      sp;
   logic [16:0]      rnd;
   logic             neg;
   logic signed [15:0] amp_d;

   always_comb begin
      fin_meta = mc_ff[HORNER_N-1];
      ep       = 62'(exp_neg_int(fin_meta.int_part)) * 62'(hp_ff[HORNER_N-1]);
      if (fin_meta.force_one) begin
         w_in = ONE_Q30;
      end else if (fin_meta.force_zero) begin
         w_in = '0;
      end else begin
         w_in = ep[60:30];
      end
   end

   // user must keep amplitude static while items are in flight; not enforced
   assign amp_d = amp;
   always_comb begin
      neg     = amp_d[15];
      mag     = neg ? 16'(-amp_d) : 16'(amp_d);
      sp      = 47'(mag) * 47'(w_ff) + (47'(1) << 29);
      rnd     = sp[46:30];
      term_in = neg ? -TERM_W'(rnd) : TERM_W'(rnd);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         w_ff    <= w_in;
         term_ff <= term_in;
      end
   end

   assign term = signed'(term_ff);

endmodule

[rtl/difference_of_gaussians_2d_eval.sv]
// ----------------------------------------------------------------------------
// difference_of_gaussians_2d_eval
// Centre-surround difference of two circular Gaussians at one grid point.
//
//   channel  direction  handshake               payload
//   req_     in         req_valid / req_stall   req_pos_x, req_pos_y
//   rsp_     out        rsp_valid / rsp_stall   rsp_response
//   csr_     in         csr_write_enable        csr_index, csr_write_data
//
// One point per cycle unless the response stalls; the 21-stage bit-per-stage
// divider and the three-stage-per-degree Horner series are the bulk of the pipeline.
// Reset restores the register defaults and empties the pipeline.
// A stalled response freezes every stage; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module difference_of_gaussians_2d_eval (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_pos_x,
   input  logic signed [15:0] req_pos_y,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [16:0] rsp_response,
   input  logic               csr_write_enable,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_write_data
);
   import dog2d_pkg::*;

   localparam int PIPE_LEN = 3 + TERM_LAT;

   logic signed [15:0] c_amp_ff, s_amp_ff, off_x_ff, off_y_ff;
   logic [15:0]        c_rad_ff, s_rad_ff;
   logic [R2_W-1:0]    c_r2_ff, s_r2_ff;
   logic [LIM_W-1:0]   c_lim_ff, s_lim_ff;

   logic               vld_ff [PIPE_LEN];
   logic               rsp_valid_ff;
   logic               advance;

   logic signed [16:0] dx_ff, dy_ff;
   logic [31:0]        sx_ff, sy_ff;
   logic [D2_W-1:0]    d2_ff;
   logic [15:0]        ax, ay;

   logic signed [TERM_W-1:0] c_term, s_term;
   logic signed [TERM_W:0]   diff;
   logic signed [16:0]       rsp_in;
   logic signed [16:0]       rsp_ff;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_amp_ff <= 16'sd4096;
         c_rad_ff <= 16'd1280;
         s_amp_ff <= 16'sd164;
         s_rad_ff <= 16'd6400;
         off_x_ff <= '0;
         off_y_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_CENTER_AMP:   c_amp_ff <= signed'(csr_write_data);
            CSR_CENTER_RAD:   c_rad_ff <= csr_write_data;
            CSR_SURROUND_AMP: s_amp_ff <= signed'(csr_write_data);
            CSR_SURROUND_RAD: s_rad_ff <= csr_write_data;
            CSR_OFFSET_X:     off_x_ff <= signed'(csr_write_data);
            CSR_OFFSET_Y:     off_y_ff <= signed'(csr_write_data);
            default: ;
         endcase
      end
   end

   // derived radius terms reach the divider with an item sent with the write
   always_ff @(posedge clock) begin
      c_r2_ff  <= 32'(c_rad_ff) * 32'(c_rad_ff);
      s_r2_ff  <= 32'(s_rad_ff) * 32'(s_rad_ff);
      c_lim_ff <= {1'b0, c_r2_ff, 4'h0} + LIM_W'(c_r2_ff);
      s_lim_ff <= {1'b0, s_r2_ff, 4'h0} + LIM_W'(s_r2_ff);
   end

   always_comb begin
      ax = dx_ff[16] ? 16'(-dx_ff) : dx_ff[15:0];
      ay = dy_ff[16] ? 16'(-dy_ff) : dy_ff[15:0];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dx_ff <= 17'(req_pos_x) - 17'(off_x_ff);
         dy_ff <= 17'(req_pos_y) - 17'(off_y_ff);
         sx_ff <= 32'(ax) * 32'(ax);
         sy_ff <= 32'(ay) * 32'(ay);
         d2_ff <= D2_W'(sx_ff) + D2_W'(sy_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PIPE_LEN; i++) begin
            vld_ff[i] <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         vld_ff[0] <= req_valid;
         for (int i = 1; i < PIPE_LEN; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
         rsp_valid_ff <= vld_ff[PIPE_LEN-1];
      end
   end

   dog2d_term u_center (
      .clock   (clock),
      .advance (advance),
      .d2      (d2_ff),
      .r2      (c_r2_ff),
      .lim     (c_lim_ff),
      .amp     (c_amp_ff),
      .term    (c_term)
   );

   dog2d_term u_surround (
      .clock   (clock),
      .advance (advance),
      .d2      (d2_ff),
      .r2      (s_r2_ff),
      .lim     (s_lim_ff),
      .amp     (s_amp_ff),
      .term    (s_term)
   );

   // subtract and saturate to Q5.12
   always_comb begin
      diff = (TERM_W+1)'(c_term) - (TERM_W+1)'(s_term);
      if (diff > 19'sd65535) begin
         rsp_in = 17'sd65535;
      end else if (diff < -19'sd65536) begin
         rsp_in = -17'sd65536;
      end else begin
         rsp_in = diff[16:0];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_response = rsp_ff;

endmodule

[test/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Checks the difference-of-Gaussians evaluator against an in-bench predictor.
// Points go in through a bursty sender; responses are taken by a receiver that
// stalls on its own pattern and are compared in order with predicted values.
// ----------------------------------------------------------------------------
module tb;
   import dog2d_pkg::*;

   localparam int LATENCY  = TERM_LAT + 4;
   localparam int WATCHDOG = 20000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [15:0] req_pos_x = '0;
   logic signed [15:0] req_pos_y = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [16:0] rsp_response;
   logic               csr_write_enable = 1'b0;
   logic [2:0]         csr_index = '0;
   logic [15:0]        csr_write_data = '0;

   // predictor copy of the registers
   logic signed [15:0] cen_amp, sur_amp, off_x, off_y;
   logic [15:0]        cen_rad, sur_rad;

   logic signed [16:0] response_queue[$];
   int                 error_count = 0;
   int                 idle_cycles = 0;
   int                 gap_max = 4;
   int                 stall_mode = 1;

   difference_of_gaussians_2d_eval u_top (.*);

   always #5 clock = ~clock;

   // exp(-d2/r^2) as a Q0.30 weight
   function automatic logic [31:0] gauss_weight(input logic [33:0] d2, input logic [15:0] rad);
      logic [63:0] r2, t, n, f, p, e;
      r2 = rad * rad;
      if (r2 == 0) return (d2 == 0) ? 32'h4000_0000 : 32'd0;
      if (64'(d2) > 64'd745 * r2) return 0;
      t = (64'(d2) << 16) / r2;
      n = t >> 16;
      f = t & 64'hFFFF;
      if (n > 16) return 0;
      p = 64'h4000_0000;
      for (int k = 9; k >= 1; k--) p = 64'h4000_0000 - ((f * p) >> 16) / k;
      e = 64'(exp_neg_int(5'(n)));
      return 32'((e * p) >> 30);
   endfunction

   function automatic longint scaled_term(input logic signed [15:0] amp, input logic [31:0] w);
      longint mag, r;
      mag = (amp < 0) ? -longint'(amp) : longint'(amp);
      r = (mag * longint'(w) + (64'd1 << 29)) >>> 30;
      return (amp < 0) ? -r : r;
   endfunction

   function automatic logic signed [16:0] dog_response(input logic signed [15:0] px,
                                                       input logic signed [15:0] py);
      longint dx, dy, r;
      logic [33:0] d2;
      dx = longint'(px) - longint'(off_x);
      dy = longint'(py) - longint'(off_y);
      d2 = 34'(dx * dx + dy * dy);
      r = scaled_term(cen_amp, gauss_weight(d2, cen_rad))
        - scaled_term(sur_amp, gauss_weight(d2, sur_rad));
      if (r > 65535) r = 65535;
      if (r < -65536) r = -65536;
      return 17'(r);
   endfunction

   // receiver stall pattern
   always @(posedge clock) begin
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         default: rsp_stall <= ($urandom_range(0, 9) < 7);
      endcase
   end

   // check each response transaction and run the watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles > WATCHDOG) begin
            $display("FAIL");
            $finish;
         end
         if (rsp_valid && !rsp_stall) begin
            if (response_queue.size() == 0) begin
               $error("unexpected response %0d", rsp_response);
               error_count++;
            end else begin
               if (rsp_response !== response_queue[0]) begin
                  $error("response: expected %0d actual %0d", response_queue[0], rsp_response);
                  error_count++;
               end
               void'(response_queue.pop_front());
            end
         end
      end
   end

   task automatic send_point(input logic signed [15:0] px, input logic signed [15:0] py);
      req_valid <= 1'b1;
      req_pos_x <= px;
      req_pos_y <= py;
      response_queue.push_back(dog_response(px, py));
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic sender_gap();
      int gap;
      gap = (gap_max == 0 || $urandom_range(0, 3) != 0) ? 0 : $urandom_range(1, gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (response_queue.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      case (idx)
         CSR_CENTER_AMP:   cen_amp = value;
         CSR_CENTER_RAD:   cen_rad = value;
         CSR_SURROUND_AMP: sur_amp = value;
         CSR_SURROUND_RAD: sur_rad = value;
         CSR_OFFSET_X:     off_x = value;
         CSR_OFFSET_Y:     off_y = value;
         default: ;
      endcase
   endtask

   task automatic configure(input logic [15:0] ca, input logic [15:0] cr, input logic [15:0] sa,
                            input logic [15:0] sr, input logic [15:0] ox, input logic [15:0] oy);
      write_reg(CSR_CENTER_AMP, ca);
      write_reg(CSR_CENTER_RAD, cr);
      write_reg(CSR_SURROUND_AMP, sa);
      write_reg(CSR_SURROUND_RAD, sr);
      write_reg(CSR_OFFSET_X, ox);
      write_reg(CSR_OFFSET_Y, oy);
      csr_write_enable <= 1'b0;
   endtask

   // reset defaults, field and register extremes, center point and zero radius
   task automatic test_directed();
      logic signed [15:0] ext[5] = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF, 16'sh0100};
      foreach (ext[i]) send_point(ext[i], ext[(i + 2) % 5]);
      send_point(16'sh0500, 16'sh0000);
      send_point(16'sh2000, 16'sh1000);
      drain();
      configure(16'h7FFF, 16'h0000, 16'h8000, 16'h0000, 16'h0000, 16'h0000);
      send_point(16'sh0000, 16'sh0000);
      send_point(16'sh0001, 16'sh0000);
      drain();
      configure(16'h8000, 16'hFFFF, 16'h7FFF, 16'h0001, 16'h8000, 16'h7FFF);
      send_point(16'sh7FFF, 16'sh8000);
      send_point(16'sh8000, 16'sh7FFF);
      send_point(16'sh8001, 16'sh7FFE);
      drain();
      // surround tail: either side of the predictor's cutoff, and n near 16
      configure(16'h1000, 16'h0100, 16'h1000, 16'h0100, 16'h0000, 16'h0000);
      send_point(16'sh1B4B, 16'sh0000);
      send_point(16'sh1B4C, 16'sh0000);
      send_point(16'sh0400, 16'sh0000);
      send_point(16'sh0410, 16'sh0000);
      send_point(16'sh0000, 16'sh1000);
      drain();
   endtask

   task automatic test_random(input int items);
      int burst;
      while (items > 0) begin
         burst = $urandom_range(1, 30);
         repeat (burst) begin
            logic signed [15:0] px, py;
            if ($urandom_range(0, 3) == 0) begin
               px = 16'($urandom);
               py = 16'($urandom);
            end else begin
               // mostly near the center so the weights are nonzero
               px = off_x + 16'($signed(17'($urandom_range(0, 4095)) - 17'sd2048));
               py = off_y + 16'($signed(17'($urandom_range(0, 4095)) - 17'sd2048));
            end
            send_point(px, py);
            items--;
         end
         sender_gap();
      end
      drain();
   endtask

   task automatic random_config();
      logic [15:0] r1, r2;
      r1 = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2047));
      r2 = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4095));
      configure(16'($urandom), r1, 16'($urandom), r2,
                16'($urandom_range(0, 2047)), 16'($urandom_range(0, 2047)));
   endtask

   initial begin
      cen_amp = 16'sd4096; cen_rad = 16'd1280; sur_amp = 16'sd164;
      sur_rad = 16'd6400;  off_x = '0;         off_y = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      configure(16'd4096, 16'd1280, 16'd164, 16'd6400, 16'd0, 16'd0);
      stall_mode = 0; gap_max = 0;
      test_random(150);
      stall_mode = 2; gap_max = 12;
      test_random(150);
      for (int phase = 0; phase < 6; phase++) begin
         stall_mode = phase % 3;
         gap_max = (phase % 2) ? 6 : 0;
         random_config();
         test_random(120);
      end
      if (error_count == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end
endmodule
